FILE: sv/flr_pkg.sv
// Package with shared constants, types and the opcode and kind codes.
package flr_pkg;
  localparam int RingDepthDef  = 512;
  localparam int MaxPayloadDef = 256;
  localparam int ReplyDepthDef = 32;

  localparam logic [7:0] HdrByte      = 8'h7E;
  localparam logic [7:0] StatusOk     = 8'h01;
  localparam logic [7:0] StatusRepeat = 8'h02;
  localparam logic [7:0] StatusBad    = 8'h10;
  localparam logic [7:0] StatusReplay = 8'h00;
  localparam logic [7:0] PadByte      = 8'hFF;

  typedef enum logic [1:0] {
    OP_LINK  = 2'd0,
    OP_POP   = 2'd1,
    OP_APPEND = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_POP   = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;
endpackage

FILE: sv/flr_if.sv
// Valid/ready channel interfaces for input and result items.
interface flr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface flr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

FILE: sv/flr_sum.sv
// Shared 16-bit adder that accumulates big-endian byte pairs.
module flr_sum (
  input  logic        clk_i,
  input  logic        clear_i,
  input  logic        add_i,
  input  logic [15:0] init_i,
  input  logic [15:0] addend_i,
  output logic [15:0] sum_o
);
  logic [15:0] sum_q;
  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      sum_q <= init_i;
    end else if (add_i) begin
      sum_q <= sum_q + addend_i;
    end
  end
  assign sum_o = sum_q;
endmodule

FILE: sv/framed_link_receiver_with_ack.sv
// Top level of the framed link receiver with acknowledge.
// Usage: in_i carries items (opcode, data_byte); out_o carries result items
// (kind, out_byte, last). Opcode 0 feeds one received link byte into the
// frame parser, opcode 1 pops a payload byte from the receive ring, opcode 2
// appends a byte to the stored reply and opcode 3 clears the reply.
// Frames are 0x7E, length, count, payload, then a 16-bit sum of byte pairs.
// A frame with a good sum is committed by a sequencer that copies the
// payload into the ring, then sends reply frames one byte at a time; a single
// shared 16-bit adder forms both the incoming and the outgoing check.
// The block takes one item at a time and drops ready while it works.
// A link byte that ends no frame, an append or a clear is done in S_IDLE.
// A pop passes through S_POPOUT or S_EMPTY, which emits its result into the output register.
// A closing byte copies an in-order payload into the ring, a read and then a
// write per byte, then sends the status frame; a repeated count adds a second
// frame with each reply byte a memory read, then the send.
// Results leave through one output register; while the receiver stalls, the
// sequencer waits and holds the pending byte. Reset empties the ring and
// reply, clears the counts and puts the parser back to hunting for 0x7E.
module framed_link_receiver_with_ack #(
  parameter int RING_DEPTH  = flr_pkg::RingDepthDef,
  parameter int MAX_PAYLOAD = flr_pkg::MaxPayloadDef,
  parameter int REPLY_DEPTH = flr_pkg::ReplyDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  flr_in_if.sink    in_i,
  flr_out_if.source out_o
);
  import flr_pkg::*;

  localparam int RW = $clog2(RING_DEPTH);
  localparam int PW = $clog2(MAX_PAYLOAD);
  localparam int YW = $clog2(REPLY_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_COPYRD = 9'b000000010,
    S_COPYWR = 9'b000000100,
    S_POPOUT = 9'b000001000,
    S_EMPTY  = 9'b000010000,
    S_FBYTE  = 9'b000100000,
    S_FRD    = 9'b001000000,
    S_FCKHI  = 9'b010000000,
    S_FCKLO  = 9'b100000000
  } state_e;

  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_LEN   = 6'b000010,
    PH_COUNT = 6'b000100,
    PH_DATA  = 6'b001000,
    PH_SUMHI = 6'b010000,
    PH_SUMLO = 6'b100000
  } phase_e;

  state_e        state_q, state_d;
  phase_e        phase_q;
  logic [7:0]    len_q, seq_q, idx_q, shi_q, acc_q, prev_q;
  logic [RW-1:0] wp_q, rp_q, wp_nx;
  logic [YW-1:0] rlen_q;
  logic [7:0]    pay_mem [MAX_PAYLOAD];
  logic [7:0]    ring_mem [RING_DEPTH];
  logic [7:0]    rply_mem [REPLY_DEPTH];
  logic [7:0]    pay_rd_q, ring_rd_q, rply_rd_q;

  // Frame sequencer.
  logic [7:0]    cnt_q;       // byte counter within the ring copy or the frame
  logic          second_q;    // replay frame follows the current one
  logic [7:0]    status_q;
  logic [YW-1:0] flen_q;      // payload length of the frame being sent

  // Output register.
  logic          ov_q;
  out_item_t     od_q;

  logic          acc_in, ofree;
  logic          sclr, sadd;
  logic [15:0]   sinit, saddend, sum;
  logic [7:0]    expect_c, hdr_byte, fbyte;
  logic          seq_ok, frame_hit, flast, copy_done;
  logic          emit, elast;
  kind_e         ekind;
  logic [7:0]    ebyte;

  assign in_i.ready = (state_q == S_IDLE);
  assign acc_in = in_i.valid && in_i.ready;
  assign out_o.valid = ov_q;
  assign out_o.kind = od_q.kind;
  assign out_o.out_byte = od_q.out_byte;
  assign out_o.last = od_q.last;
  assign ofree = !ov_q || out_o.ready;

  // The shared adder: it accumulates the incoming check while a frame is
  // parsed and the outgoing check while a reply frame is sent.
  flr_sum u_sum (.clk_i, .clear_i(sclr), .add_i(sadd), .init_i(sinit),
                 .addend_i(saddend), .sum_o(sum));

  assign wp_nx = (wp_q == RW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  // The count after 255 is 1, so zero is never expected as the next count.
  assign expect_c = (acc_q == 8'd255) ? 8'd1 : acc_q + 8'd1;
  assign seq_ok = (seq_q == expect_c) || (seq_q == 8'd0);
  // The pad for an even length is already folded into the sum on the high
  // check byte, so the closing byte compares against the sum directly.
  assign frame_hit = acc_in && (in_i.opcode == OP_LINK) && (phase_q == PH_SUMLO) &&
                     ({shi_q, in_i.data_byte} == sum);
  assign flast = (cnt_q == 8'(flen_q) + 8'd4);
  assign copy_done = ({1'b0, cnt_q} + 9'd1 >= {1'b0, len_q});

  // Header bytes of the frame being sent, index 0 to 4.
  always_comb begin
    case (cnt_q[2:0])
      3'd0: hdr_byte = HdrByte;
      3'd1: hdr_byte = 8'(flen_q);
      3'd2: hdr_byte = acc_q;
      3'd3: hdr_byte = prev_q;
      default: hdr_byte = status_q;
    endcase
  end

  assign fbyte = (cnt_q < 8'd5) ? hdr_byte : rply_rd_q;

  always_comb begin
    state_d = state_q;
    emit = 1'b0; ekind = KIND_TX; ebyte = '0; elast = 1'b0;
    sclr = 1'b0; sadd = 1'b0; sinit = '0; saddend = '0;
    case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          case (in_i.opcode)
            OP_LINK: begin
              case (phase_q)
                PH_HUNT: if (in_i.data_byte == HdrByte) begin
                  sclr = 1'b1; sinit = {HdrByte, 8'h00};
                end
                PH_LEN: begin
                  sadd = 1'b1; saddend = {8'h00, in_i.data_byte};
                end
                PH_COUNT: begin
                  sadd = 1'b1; saddend = {in_i.data_byte, 8'h00};
                end
                PH_DATA: begin
                  sadd = 1'b1;
                  saddend = idx_q[0] ? {in_i.data_byte, 8'h00} : {8'h00, in_i.data_byte};
                end
                PH_SUMHI: begin
                  // An even payload leaves the last byte of the frame unpaired.
                  sadd = !len_q[0]; saddend = {8'h00, PadByte};
                end
                PH_SUMLO: if (frame_hit) begin
                  state_d = (seq_ok && len_q != 8'd0) ? S_COPYRD : S_FBYTE;
                end
                default: ;
              endcase
            end
            OP_POP: state_d = (rp_q != wp_q) ? S_POPOUT : S_EMPTY;
            default: ;
          endcase
        end
      end
      S_COPYRD: state_d = S_COPYWR;
      S_COPYWR: state_d = copy_done ? S_FBYTE : S_COPYRD;
      S_POPOUT: if (ofree) begin
        emit = 1'b1; ekind = KIND_POP; ebyte = ring_rd_q; elast = 1'b1;
        state_d = S_IDLE;
      end
      S_EMPTY: if (ofree) begin
        emit = 1'b1; ekind = KIND_EMPTY; elast = 1'b1;
        state_d = S_IDLE;
      end
      S_FRD: state_d = S_FBYTE;
      S_FBYTE: if (ofree) begin
        // Bytes at even positions are the high half of a pair; an unpaired
        // last byte is completed with the pad byte.
        emit = 1'b1; ebyte = fbyte;
        if (cnt_q == 8'd0) begin
          sclr = 1'b1; sinit = {fbyte, 8'h00};
        end else begin
          sadd = 1'b1;
          saddend = cnt_q[0] ? {8'h00, fbyte} : {fbyte, flast ? PadByte : 8'h00};
        end
        state_d = flast ? S_FCKHI : (cnt_q < 8'd4) ? S_FBYTE : S_FRD;
      end
      S_FCKHI: if (ofree) begin
        emit = 1'b1; ebyte = sum[15:8];
        state_d = S_FCKLO;
      end
      S_FCKLO: if (ofree) begin
        emit = 1'b1; ebyte = sum[7:0]; elast = !second_q;
        state_d = second_q ? S_FBYTE : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; phase_q <= PH_HUNT;
      len_q <= '0; seq_q <= '0; idx_q <= '0; shi_q <= '0;
      acc_q <= '0; prev_q <= '0; wp_q <= '0; rp_q <= '0; rlen_q <= '0;
      cnt_q <= '0; second_q <= 1'b0; status_q <= '0; flen_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
      if (acc_in) begin
        case (in_i.opcode)
          OP_LINK: begin
            case (phase_q)
              PH_HUNT: phase_q <= (in_i.data_byte == HdrByte) ? PH_LEN : PH_HUNT;
              PH_LEN: begin
                len_q <= in_i.data_byte;
                phase_q <= (9'(in_i.data_byte) > 9'(MAX_PAYLOAD)) ? PH_HUNT : PH_COUNT;
              end
              PH_COUNT: begin
                seq_q <= in_i.data_byte; idx_q <= '0;
                phase_q <= (len_q == 8'd0) ? PH_SUMHI : PH_DATA;
              end
              PH_DATA: begin
                if ({1'b0, idx_q} + 9'd1 >= {1'b0, len_q}) phase_q <= PH_SUMHI;
                else idx_q <= idx_q + 8'd1;
              end
              PH_SUMHI: begin
                shi_q <= in_i.data_byte; phase_q <= PH_SUMLO;
              end
              PH_SUMLO: begin
                phase_q <= PH_HUNT;
                if (frame_hit) begin
                  cnt_q <= '0; flen_q <= '0; second_q <= 1'b0;
                  if (seq_ok) begin
                    status_q <= StatusOk;
                    prev_q <= (seq_q == 8'd0) ? 8'd0 : acc_q;
                    acc_q <= seq_q;
                  end else if (seq_q == acc_q) begin
                    status_q <= StatusRepeat; second_q <= 1'b1;
                  end else begin
                    status_q <= StatusBad;
                  end
                end
              end
              default: phase_q <= PH_HUNT;
            endcase
          end
          OP_APPEND: if (rlen_q != YW'(REPLY_DEPTH - 1)) rlen_q <= rlen_q + 1'b1;
          OP_CLEAR: rlen_q <= '0;
          default: ;
        endcase
      end
      case (state_q)
        S_COPYWR: begin
          if (wp_nx != rp_q) wp_q <= wp_nx;
          cnt_q <= copy_done ? '0 : cnt_q + 8'd1;
        end
        S_POPOUT: if (emit) rp_q <= (rp_q == RW'(RING_DEPTH - 1)) ? '0 : rp_q + 1'b1;
        S_FBYTE: if (emit) cnt_q <= cnt_q + 8'd1;
        S_FCKLO: if (emit && second_q) begin
          second_q <= 1'b0; cnt_q <= '0;
          status_q <= StatusReplay; flen_q <= rlen_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      od_q.kind <= ekind; od_q.out_byte <= ebyte; od_q.last <= elast;
    end
    if (acc_in && in_i.opcode == OP_LINK && phase_q == PH_DATA &&
        9'(idx_q) < 9'(MAX_PAYLOAD))
      pay_mem[PW'(idx_q)] <= in_i.data_byte;
    if (acc_in && in_i.opcode == OP_APPEND && rlen_q != YW'(REPLY_DEPTH - 1))
      rply_mem[rlen_q] <= in_i.data_byte;
    if (state_q == S_COPYWR && wp_nx != rp_q) ring_mem[wp_q] <= pay_rd_q;
    pay_rd_q <= pay_mem[PW'(cnt_q)];
    ring_rd_q <= ring_mem[rp_q];
    rply_rd_q <= rply_mem[YW'(cnt_q - 8'd5)];
  end
endmodule
